>>> hw/rtl/shsd_pkg.sv
`default_nettype none

package shsd_pkg;

    // Register width of the reduction and the digit that moves per cycle.
    localparam int WORD_W  = 256;
    localparam int DIGIT_W = 16;
    localparam int NDIG    = WORD_W / DIGIT_W;
    localparam int POS_W   = $clog2(NDIG);
    localparam int DBW     = $clog2(DIGIT_W);
    localparam int SHAMT_W = POS_W + DBW;
    localparam int LEN_W   = $clog2(WORD_W) + 1;

    // The results keep the low half of |tau| and the low 127 bits of |rho|.
    localparam int HALF_W = 128;
    localparam int NOUT   = HALF_W / DIGIT_W;

    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(NDIG - 1);
    localparam logic [POS_W-1:0] OUT_LAST  = POS_W'(NOUT - 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(127);
    localparam logic [LEN_W-1:0] LEN_ORDER = LEN_W'(253);

    // Group order l = 2^252 + 27742317777372353535851937790883648493.
    localparam logic [WORD_W-1:0] ORDER_L = {
        64'h1000000000000000, 64'h0000000000000000,
        64'h14def9dea2f79cd6, 64'h5812631a5cf5d3ed
    };

    typedef struct packed {
        logic [60:0] h_limb3;
        logic [63:0] h_limb2;
        logic [63:0] h_limb1;
        logic [63:0] h_limb0;
    } in_item_t;

    typedef struct packed {
        logic [63:0] rho_low;
        logic [62:0] rho_high;
        logic [63:0] tau_low;
        logic [63:0] tau_high;
        logic        sign_flip;
    } out_item_t;

    // Bit lengths of a streamed value and of its negation.
    typedef struct packed {
        logic [LEN_W-1:0] len_pos;
        logic [LEN_W-1:0] len_neg;
    } len_pair_t;

endpackage

`default_nettype wire

>>> hw/rtl/shsd_len_track.sv
`default_nettype none

// Watches a value go by one digit per stepped cycle, least significant
// first; keeps the bit length of it and of its two's-complement negation.
module shsd_len_track (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [shsd_pkg::POS_W-1:0]   pos,
    input  wire logic [shsd_pkg::DIGIT_W-1:0] digit,
    output shsd_pkg::len_pair_t               lens
);

    localparam int D = shsd_pkg::DIGIT_W;

    function automatic logic [shsd_pkg::LEN_W-1:0] msb_len(input logic [D-1:0] d);
        logic [shsd_pkg::LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < D; i++)
        begin
            if (d[i])
            begin
                n = shsd_pkg::LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    shsd_pkg::len_pair_t        lens_reg;
    shsd_pkg::len_pair_t        lens_next;
    logic                       nc_reg;
    logic                       nc_next;
    logic                       n_cin;
    logic [D:0]                 n_sum;
    logic [shsd_pkg::LEN_W-1:0] base;

    always_comb
    begin
        n_cin = (pos == '0) ? 1'b1 : nc_reg;
        n_sum = {1'b0, ~digit} + (D + 1)'(n_cin);
        base  = shsd_pkg::LEN_W'({pos, {shsd_pkg::DBW{1'b0}}});
        lens_next = lens_reg;
        nc_next   = nc_reg;
        if (step)
        begin
            nc_next = n_sum[D];
            if (pos == '0)
            begin
                lens_next.len_pos = '0;
                lens_next.len_neg = '0;
            end
            if (digit != '0)
            begin
                lens_next.len_pos = base + msb_len(digit);
            end
            if (n_sum[D-1:0] != '0)
            begin
                lens_next.len_neg = base + msb_len(n_sum[D-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lens_reg <= '0;
            nc_reg   <= 1'b0;
        end
        else
        begin
            lens_reg <= lens_next;
            nc_reg   <= nc_next;
        end
    end

    assign lens = lens_reg;

endmodule

`default_nettype wire

>>> hw/rtl/scalar_half_size_decompose_unit.sv
// Half-size decomposition of an Ed25519 scalar by binary extended Euclid.
// An item on the h channel (h_valid/h_ready) carries a scalar h below 2^253
// as four limbs; an item on the res channel (res_valid/res_ready) returns
// |rho| (low 127 bits), |tau| (low 128 bits) and the XOR of their signs.
// The unit works on one item at a time. The 256-bit registers move through
// 16-bit adders one digit per cycle, r also through the length tracker,
// so each cycle of a pass touches only one digit of each register.
// The unit first measures h. It then makes one pass per reduction step,
// followed by a restore phase when q, the digit part of the shift count
// (0 to 15), is not zero, and by a decision. Last it forms the magnitudes
// and posts the result. A typical scalar needs some 130 to 250 passes.
// h_ready is high only while the unit is idle. The result sits in its own
// output register, so a new item may be taken while the receiver stalls;
// a finished item then waits in place until the output register frees up.
// Reset, asynchronous and active low, drops any item in flight and any
// result not yet taken, and leaves the unit idle and ready.
`default_nettype none

module scalar_half_size_decompose_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               h_valid,
    output logic                    h_ready,
    input  wire shsd_pkg::in_item_t h_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output shsd_pkg::out_item_t     res_item
);

    localparam int W = shsd_pkg::WORD_W;
    localparam int D = shsd_pkg::DIGIT_W;
    localparam int H = shsd_pkg::HALF_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SETUP,
        ST_PASS,
        ST_RESTORE,
        ST_DECIDE,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [shsd_pkg::POS_W-1:0]   cnt_reg, cnt_next;
    logic [shsd_pkg::LEN_W-1:0]   len0_reg, len0_next;
    logic [shsd_pkg::LEN_W-1:0]   len1_reg, len1_next;
    logic                         res_valid_reg, res_valid_next;
    shsd_pkg::out_item_t          res_item_reg, res_item_next;

    // The remainder pair (r0, r1) and cofactor pair (t0, t1).
    logic [W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [D-1:0] r_prev_reg, r_prev_next, t_prev_reg, t_prev_next;
    logic         r_carry_reg, r_carry_next, t_carry_reg, t_carry_next;
    logic         same_reg, same_next;
    logic         r_sign_reg, r_sign_next, t_sign_reg, t_sign_next;
    logic [H-1:0] rho_reg, rho_next, tau_reg, tau_next;

    logic [shsd_pkg::SHAMT_W-1:0] shamt;
    logic [shsd_pkg::POS_W-1:0]   q_amt;
    logic [shsd_pkg::DBW-1:0]     b_amt;
    logic                         first;
    logic                         feed_on;
    logic [D-1:0]                 r_feed, t_feed, r_prev_in, t_prev_in;
    logic [2*D-1:0]               r_pair, t_pair;
    logic [D-1:0]                 r_shift, t_shift;
    logic                         same;
    logic [D:0]                   r_sum, t_sum;
    logic                         r_sg, t_sg;
    logic [D:0]                   r_fin, t_fin;
    logic [shsd_pkg::LEN_W-1:0]   len_r;
    logic                         grow;
    logic [shsd_pkg::LEN_W-1:0]   len1_new;
    logic                         trk_step;
    logic [D-1:0]                 trk_digit;
    shsd_pkg::len_pair_t          lens;

    assign h_ready   = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // The lengths stay put for the whole pass, so the shift count does too.
    // Its digit part delays the entry of r1 and t1; its bit part is applied
    // by splicing each fed digit with the one before it.
    always_comb
    begin
        shamt   = len0_reg[shsd_pkg::SHAMT_W-1:0] - len1_reg[shsd_pkg::SHAMT_W-1:0];
        q_amt   = shamt[shsd_pkg::DBW +: shsd_pkg::POS_W];
        b_amt   = shamt[shsd_pkg::DBW-1:0];
        first   = (cnt_reg == '0);
        feed_on = (cnt_reg >= q_amt);

        r_feed    = feed_on ? r1_reg[D-1:0] : '0;
        t_feed    = feed_on ? t1_reg[D-1:0] : '0;
        r_prev_in = first ? '0 : r_prev_reg;
        t_prev_in = first ? '0 : t_prev_reg;
        r_pair    = {r_feed, r_prev_in} << b_amt;
        t_pair    = {t_feed, t_prev_in} << b_amt;
        r_shift   = r_pair[2*D-1:D];
        t_shift   = t_pair[2*D-1:D];

        // Subtract when r0 and r1 share a sign, add otherwise. The signs are
        // read at the first digit, before any register has rotated.
        same  = first ? (r0_reg[W-1] == r1_reg[W-1]) : same_reg;
        r_sum = {1'b0, r0_reg[D-1:0]} + {1'b0, r_shift ^ {D{same}}}
              + (D + 1)'(first ? same : r_carry_reg);
        t_sum = {1'b0, t0_reg[D-1:0]} + {1'b0, t_shift ^ {D{same}}}
              + (D + 1)'(first ? same : t_carry_reg);

        // Conditional negation of r1 and t1 for the magnitudes.
        r_sg  = first ? r1_reg[W-1] : r_sign_reg;
        t_sg  = first ? t1_reg[W-1] : t_sign_reg;
        r_fin = {1'b0, r1_reg[D-1:0] ^ {D{r_sg}}}
              + (D + 1)'(first ? r_sg : r_carry_reg);
        t_fin = {1'b0, t1_reg[D-1:0] ^ {D{t_sg}}}
              + (D + 1)'(first ? t_sg : t_carry_reg);

        // After a pass r0 holds the new remainder r.
        len_r    = r0_reg[W-1] ? lens.len_neg : lens.len_pos;
        grow     = (len_r > len1_reg);
        len1_new = grow ? len1_reg : len_r;

        trk_step  = (state_reg == ST_INIT) || (state_reg == ST_PASS);
        trk_digit = (state_reg == ST_INIT) ? r1_reg[D-1:0] : r_sum[D-1:0];
    end

    shsd_len_track u_len_track (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (trk_step),
        .pos   (cnt_reg),
        .digit (trk_digit),
        .lens  (lens)
    );

    // Sequencer: state, counter, lengths and the output register.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len0_next      = len0_reg;
        len1_next      = len1_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_item_next  = res_item_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (h_valid)
                begin
                    len0_next  = shsd_pkg::LEN_ORDER;
                    cnt_next   = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == shsd_pkg::POS_LAST)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                len1_next  = lens.len_pos;
                cnt_next   = '0;
                state_next = (lens.len_pos > shsd_pkg::LEN_LIMIT) ? ST_PASS : ST_FINISH;
            end
            ST_PASS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == shsd_pkg::POS_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (q_amt == '0) ? ST_DECIDE : ST_RESTORE;
                end
            end
            ST_RESTORE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == q_amt - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (grow)
                begin
                    len0_next = len_r;
                end
                else
                begin
                    len0_next = len1_reg;
                    len1_next = len_r;
                end
                cnt_next   = '0;
                state_next = (len1_new > shsd_pkg::LEN_LIMIT) ? ST_PASS : ST_FINISH;
            end
            ST_FINISH:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == shsd_pkg::OUT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_item_next.rho_low   = rho_reg[63:0];
                    res_item_next.rho_high  = rho_reg[126:64];
                    res_item_next.tau_low   = tau_reg[63:0];
                    res_item_next.tau_high  = tau_reg[127:64];
                    res_item_next.sign_flip = r_sign_reg ^ t_sign_reg;
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len0_reg      <= '0;
            len1_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len0_reg      <= len0_next;
            len1_reg      <= len1_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    // Datapath. Registers rotate right by one digit per cycle; r0 and t0
    // take the new digits of r and t at the top as their own leave the bottom.
    // r1 and t1 start to rotate only once the digit delay has run out, and
    // finish their full turn during the restore cycles.
    always_comb
    begin
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        r_prev_next  = r_prev_reg;
        t_prev_next  = t_prev_reg;
        r_carry_next = r_carry_reg;
        t_carry_next = t_carry_reg;
        same_next    = same_reg;
        r_sign_next  = r_sign_reg;
        t_sign_next  = t_sign_reg;
        rho_next     = rho_reg;
        tau_next     = tau_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (h_valid)
                begin
                    r0_next = shsd_pkg::ORDER_L;
                    r1_next = W'({h_item.h_limb3, h_item.h_limb2,
                                  h_item.h_limb1, h_item.h_limb0});
                    t0_next = '0;
                    t1_next = W'(1);
                end
            end
            ST_INIT:
            begin
                r1_next = {r1_reg[D-1:0], r1_reg[W-1:D]};
            end
            ST_PASS:
            begin
                r0_next      = {r_sum[D-1:0], r0_reg[W-1:D]};
                t0_next      = {t_sum[D-1:0], t0_reg[W-1:D]};
                r_carry_next = r_sum[D];
                t_carry_next = t_sum[D];
                r_prev_next  = r_feed;
                t_prev_next  = t_feed;
                same_next    = same;
                if (feed_on)
                begin
                    r1_next = {r1_reg[D-1:0], r1_reg[W-1:D]};
                    t1_next = {t1_reg[D-1:0], t1_reg[W-1:D]};
                end
            end
            ST_RESTORE:
            begin
                r1_next = {r1_reg[D-1:0], r1_reg[W-1:D]};
                t1_next = {t1_reg[D-1:0], t1_reg[W-1:D]};
            end
            ST_DECIDE:
            begin
                // The new remainder did not outgrow r1: the pairs move down.
                if (!grow)
                begin
                    r0_next = r1_reg;
                    r1_next = r0_reg;
                    t0_next = t1_reg;
                    t1_next = t0_reg;
                end
            end
            ST_FINISH:
            begin
                r1_next      = {r1_reg[D-1:0], r1_reg[W-1:D]};
                t1_next      = {t1_reg[D-1:0], t1_reg[W-1:D]};
                rho_next     = {r_fin[D-1:0], rho_reg[H-1:D]};
                tau_next     = {t_fin[D-1:0], tau_reg[H-1:D]};
                r_carry_next = r_fin[D];
                t_carry_next = t_fin[D];
                r_sign_next  = r_sg;
                t_sign_next  = t_sg;
            end
            ST_SETUP, ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        r_prev_reg  <= r_prev_next;
        t_prev_reg  <= t_prev_next;
        r_carry_reg <= r_carry_next;
        t_carry_reg <= t_carry_next;
        same_reg    <= same_next;
        r_sign_reg  <= r_sign_next;
        t_sign_reg  <= t_sign_next;
        rho_reg     <= rho_next;
        tau_reg     <= tau_next;
    end

    // An accepted item keeps the unit busy for at least the next cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (h_valid && h_ready) |=> !h_ready
    ) else $error("input accepted again right after an accept");

    // r1 is never longer than r0 while a pass runs.
    a_len_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS) |-> (len1_reg <= len0_reg)
    ) else $error("r1 longer than r0 during a pass");

    // A result appears only out of the posting state.
    a_post_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_OUT)
    ) else $error("result posted outside the posting state");

    // The decision follows a completed pass or its restore cycles.
    a_decide_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |->
            $past(state_reg == ST_PASS || state_reg == ST_RESTORE)
    ) else $error("decision reached without a pass");

endmodule

`default_nettype wire

>>> verif/decompose_scoreboard_pkg.sv
`timescale 1ns / 100ps

package decompose_check_pkg;

    class half_size_scoreboard;

        shsd_pkg::out_item_t predicted_halves[$];
        int unsigned         mismatches = 0;
        int unsigned         results_checked = 0;

        // Bit length of the magnitude of a signed 256-bit value.
        static function int unsigned magnitude_len(logic [255:0] x);
            logic [255:0] m;
            m = x[255] ? -x : x;
            for (int i = 255; i >= 0; i--)
            begin
                if (m[i])
                begin
                    return i + 1;
                end
            end
            return 0;
        endfunction

        // Binary half-size extended Euclid of h against the group order.
        static function shsd_pkg::out_item_t decompose(logic [252:0] h);
            logic [255:0]        r0, r1, t0, t1, r1s, t1s, r, t, rho, tau;
            int unsigned         len0, len1, lenr;
            logic [7:0]          s;
            shsd_pkg::out_item_t res;
            r0   = shsd_pkg::ORDER_L;
            r1   = {3'b000, h};
            t0   = '0;
            t1   = 256'd1;
            len0 = 253;
            len1 = magnitude_len(r1);
            while (len1 > 127)
            begin
                s   = 8'(len0 - len1);
                r1s = r1 << s;
                t1s = t1 << s;
                if (r0[255] == r1[255])
                begin
                    r = r0 - r1s;
                    t = t0 - t1s;
                end
                else
                begin
                    r = r0 + r1s;
                    t = t0 + t1s;
                end
                lenr = magnitude_len(r);
                if (lenr > len1)
                begin
                    r0   = r;
                    t0   = t;
                    len0 = lenr;
                end
                else
                begin
                    r0   = r1;
                    t0   = t1;
                    r1   = r;
                    t1   = t;
                    len0 = len1;
                    len1 = lenr;
                end
            end
            rho           = r1[255] ? -r1 : r1;
            tau           = t1[255] ? -t1 : t1;
            res.rho_low   = rho[63:0];
            res.rho_high  = rho[126:64];
            res.tau_low   = tau[63:0];
            res.tau_high  = tau[127:64];
            res.sign_flip = r1[255] ^ t1[255];
            return res;
        endfunction

        function void note_scalar(shsd_pkg::in_item_t h);
            predicted_halves.push_back(decompose(h));
        endfunction

        function int unsigned pending();
            return predicted_halves.size();
        endfunction

        task report(string msg);
            $display("%0t: result %0d: %s", $time, results_checked, msg);
            mismatches++;
        endtask

        task check_result(shsd_pkg::out_item_t got);
            shsd_pkg::out_item_t want;
            if (predicted_halves.size() == 0)
            begin
                report($sformatf("arrived with no scalar outstanding: %h", got));
                return;
            end
            want = predicted_halves.pop_front();
            if (got.rho_low !== want.rho_low)
                report($sformatf("rho_low %h, predicted %h", got.rho_low, want.rho_low));
            if (got.rho_high !== want.rho_high)
                report($sformatf("rho_high %h, predicted %h", got.rho_high, want.rho_high));
            if (got.tau_low !== want.tau_low)
                report($sformatf("tau_low %h, predicted %h", got.tau_low, want.tau_low));
            if (got.tau_high !== want.tau_high)
                report($sformatf("tau_high %h, predicted %h", got.tau_high, want.tau_high));
            if (got.sign_flip !== want.sign_flip)
                report($sformatf("sign_flip %b, predicted %b", got.sign_flip, want.sign_flip));
            results_checked++;
        endtask

    endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 100ps

// Checks the half-size scalar decomposition unit. Scalars go in on the h
// channel; every accepted item is run through a software copy of the
// reduction and the predicted halves are queued. Each result item taken on
// the res channel is compared field by field with the oldest prediction.
module testbench;

    // Run shape. The run length is governed by the item count rather than by
    // the idling.
    localparam int ITEM_TOTAL   = 1050;
    localparam int CORNER_COUNT = 17;
    localparam int QUIET_TAIL   = 60;
    // The receiver stalls once for long enough that the unit finishes one
    // item, takes a second one, finishes that too and then holds h_ready low.
    localparam int HOLD_AFTER   = 30;
    localparam int LONG_HOLD    = 30000;
    // The long stall sits on top of one or two of the slowest items, so this
    // limit leaves a wide margin.
    localparam int STALL_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 500;

    localparam logic [252:0] ORDER = shsd_pkg::ORDER_L[252:0];

    logic                clk = 1'b0;
    logic                rst_n;
    logic                h_valid;
    logic                h_ready;
    shsd_pkg::in_item_t  h_item;
    logic                res_valid;
    logic                res_ready;
    shsd_pkg::out_item_t res_item;

    decompose_check_pkg::half_size_scoreboard sb = new();

    int unsigned scalars_taken = 0;
    int unsigned idle_cycles   = 0;
    bit          quiet_phase   = 1'b0;
    bit          long_hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    scalar_half_size_decompose_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .h_valid   (h_valid),
        .h_ready   (h_ready),
        .h_item    (h_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Offers one scalar, sometimes after a short gap with valid low, and
    // returns at the rising edge where the unit takes it. Inputs change only
    // at falling edges; h_ready is read at the rising edge before the
    // unit's own registers update.
    task automatic send_scalar(input logic [252:0] value);
        int unsigned gap;
        @(negedge clk);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            h_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        h_item  <= value;
        h_valid <= 1'b1;
        do @(posedge clk); while (!h_ready);
    endtask

    // Random scalars. Most are uniform over all 253 bits, so about half lie
    // at or above the group order. The rest are below 2^252, of a random bit
    // length up to 253 (short ones skip the loop), sparse, or near the order.
    function automatic logic [252:0] random_scalar();
        logic [255:0] v;
        int unsigned  kind;
        int unsigned  bits;
        for (int i = 0; i < 8; i++)
        begin
            v[i*32 +: 32] = $urandom;
        end
        kind = $urandom_range(0, 9);
        case (kind)
            6: v[255:252] = '0;
            7:
            begin
                bits = $urandom_range(0, 253);
                v = v & ((256'd1 << bits) - 256'd1);
                if (bits != 0)
                begin
                    v[bits-1] = 1'b1;
                end
            end
            8: v = v & {$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom};
            9: v = {3'b000, ORDER} + 256'($urandom_range(0, 4000)) - 256'd2000;
            default: ;
        endcase
        return v[252:0];
    endfunction

    // Both channels are watched here. Every accepted scalar gets its halves
    // predicted at once, every result is checked against the oldest ones,
    // and a run of cycles with no item moving on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (h_valid && h_ready)
            begin
                sb.note_scalar(h_item);
                scalars_taken++;
            end
            if (res_valid && res_ready)
            begin
                sb.check_result(res_item);
            end
            if ((h_valid && h_ready) || (res_valid && res_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // The receiver alternates between stretches with stall bursts and
    // stretches with none. Once, after a few dozen items, it stops taking
    // results for a long time so that the unit backs up. At the end of the
    // run it takes every result at once.
    initial
    begin : receiver
        int unsigned stretch_left;
        bit          stalls_on;
        res_ready    = 1'b0;
        stretch_left = 0;
        stalls_on    = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(1000, 8000);
                stalls_on    = $urandom_range(0, 2) != 0;
            end
            else
            begin
                stretch_left--;
            end
            if (!long_hold_done && scalars_taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                res_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet_phase && stalls_on && $urandom_range(0, 7) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rst_n   = 1'b0;
        h_valid = 1'b0;
        h_item  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corner scalars: zero (no pass at all), tiny values, the lengths
        // just under and just over the stopping point, the order itself and
        // its neighbors, the largest 253-bit value, alternating patterns and
        // each limb full on its own.
        send_scalar(253'd0);
        send_scalar(253'd1);
        send_scalar(253'd3);
        send_scalar((253'd1 << 127) - 253'd1);
        send_scalar(253'd1 << 127);
        send_scalar((253'd1 << 128) - 253'd1);
        send_scalar(253'd1 << 252);
        send_scalar(ORDER - 253'd1);
        send_scalar(ORDER);
        send_scalar(ORDER + 253'd1);
        send_scalar({253{1'b1}});
        send_scalar(253'({64{4'h5}}));
        send_scalar(253'({64{4'ha}}));
        send_scalar({189'd0, {64{1'b1}}});
        send_scalar({125'd0, {64{1'b1}}, 64'd0});
        send_scalar({61'd0, {64{1'b1}}, 128'd0});
        send_scalar({{61{1'b1}}, 192'd0});

        for (int i = 0; i < ITEM_TOTAL - CORNER_COUNT; i++)
        begin
            if (i >= ITEM_TOTAL - CORNER_COUNT - QUIET_TAIL)
            begin
                quiet_phase = 1'b1;
            end
            send_scalar(random_scalar());
        end
        @(negedge clk);
        h_valid <= 1'b0;

        // Wait for every predicted result, then a little longer so that a
        // stray extra result would still be caught.
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
